// ===== src/dew_point_from_temp_humidity_macros.svh =====
// Assertion macros for the dew point RTL.
`ifndef DEW_POINT_FROM_TEMP_HUMIDITY_MACROS_SVH
`define DEW_POINT_FROM_TEMP_HUMIDITY_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DPTH_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dew point assertion failed");
`define DPTH_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("dew point forbidden condition seen");
`else
`define DPTH_ASSERT(lbl, clk, rst_n, prop)
`define DPTH_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== src/dpth_pkg.sv =====
// Constants and elaboration-time log helpers for the dew point block.
`timescale 1ns / 1ps
`default_nettype none
package dpth_pkg;
    localparam int unsigned T_W      = 8;
    localparam int unsigned RH_W     = 7;
    localparam int unsigned A_NUM    = 17271;
    localparam int unsigned A_DEN    = 1000;
    localparam int unsigned B_NUM    = 2377;
    localparam int unsigned B_DEN    = 10;
    localparam int unsigned LN_FRAC  = 30;
    localparam logic [63:0] LN2_Q30  = 64'd744261118;
    localparam int unsigned LN_TERMS = 11;
    localparam int          DEW_MIN  = -80;
    localparam int          DEW_MAX  = 85;
    // Whole-degree quotient width of the second divider.
    localparam int unsigned DEG_QW   = 10;

    // Unsigned 64-bit quotient by shift and subtract; used only for constant tables.
    function automatic logic [63:0] cdiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], num[i]};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Unsigned Q30 natural log of n, for n in 1..127; used only for constant tables.
    function automatic logic [63:0] ln_q30(input int unsigned n);
        logic [63:0] base;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] pw;
        logic [63:0] sum;
        int unsigned k;
        k = 0;
        for (int unsigned i = 1; i < 7; i++) begin
            if ((n >> i) != 0) k = i;
        end
        base = 64'd1 << k;
        z    = cdiv((64'(n) - base) << LN_FRAC, 64'(n) + base);
        z2   = (z * z) >> LN_FRAC;
        pw   = z;
        sum  = 64'd0;
        for (int unsigned j = 0; j < LN_TERMS; j++) begin
            sum = sum + cdiv(pw, 64'(2 * j + 1));
            pw  = (pw * z2) >> LN_FRAC;
        end
        return 64'(k) * LN2_Q30 + 64'd2 * sum;
    endfunction

    // ln(n/100) rounded to the given fraction bits, ties away from zero.
    function automatic logic signed [63:0] ln_ratio_qf(input int unsigned n,
                                                       input int unsigned frac);
        logic signed [63:0] v;
        logic [63:0] mag;
        logic [63:0] r;
        int unsigned sh;
        v   = signed'(ln_q30(n)) - signed'(ln_q30(100));
        sh  = LN_FRAC - frac;
        mag = (v < 0) ? unsigned'(-v) : unsigned'(v);
        r   = (mag + (64'd1 << (sh - 1))) >> sh;
        return (v < 0) ? -signed'(r) : signed'(r);
    endfunction
endpackage
`default_nettype wire

// ===== src/dpth_div_cell.sv =====
// One restoring division cell: decides one quotient bit and passes the item on.
`timescale 1ns / 1ps
`default_nettype none
module dpth_div_cell #(
    parameter int unsigned NW     = 45,
    parameter int unsigned QW     = 21,
    parameter int unsigned SIDE_W = 2,
    parameter int unsigned SHIFT  = 0
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_vld,
    output logic                   in_rdy,
    input  wire logic [NW-1:0]     in_rem,
    input  wire logic [NW-1:0]     in_den,
    input  wire logic [QW-1:0]     in_quo,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_vld,
    input  wire logic              out_rdy,
    output logic [NW-1:0]          out_rem,
    output logic [NW-1:0]          out_den,
    output logic [QW-1:0]          out_quo,
    output logic [SIDE_W-1:0]      out_side
);
    localparam int unsigned EW = NW + QW;

    logic              vld_reg;
    logic [NW-1:0]     rem_reg, rem_next;
    logic [NW-1:0]     den_reg;
    logic [QW-1:0]     quo_reg, quo_next;
    logic [SIDE_W-1:0] side_reg;
    logic [EW-1:0]     dsh, remx, diff;
    logic              take;

    assign in_rdy = !vld_reg || out_rdy;

    always_comb begin
        dsh      = EW'(in_den) << SHIFT;
        remx     = EW'(in_rem);
        take     = remx >= dsh;
        diff     = remx - dsh;
        rem_next = take ? diff[NW-1:0] : in_rem;
        quo_next = {in_quo[QW-2:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_rdy) begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_rdy && in_vld) begin
            rem_reg  <= rem_next;
            den_reg  <= in_den;
            quo_reg  <= quo_next;
            side_reg <= in_side;
        end
    end

    assign out_vld  = vld_reg;
    assign out_rem  = rem_reg;
    assign out_den  = den_reg;
    assign out_quo  = quo_reg;
    assign out_side = side_reg;
endmodule
`default_nettype wire

// ===== src/dpth_div_chain.sv =====
// Row of division cells, one quotient bit per cell, most significant bit first.
`timescale 1ns / 1ps
`default_nettype none
module dpth_div_chain #(
    parameter int unsigned NW     = 45,
    parameter int unsigned QW     = 21,
    parameter int unsigned SIDE_W = 2
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_vld,
    output logic                   in_rdy,
    input  wire logic [NW-1:0]     in_num,
    input  wire logic [NW-1:0]     in_den,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_vld,
    input  wire logic              out_rdy,
    output logic [NW-1:0]          out_rem,
    output logic [NW-1:0]          out_den,
    output logic [QW-1:0]          out_quo,
    output logic [SIDE_W-1:0]      out_side
);
    logic              vld  [QW+1];
    logic              rdy  [QW+1];
    logic [NW-1:0]     rem  [QW+1];
    logic [NW-1:0]     den  [QW+1];
    logic [QW-1:0]     quo  [QW+1];
    logic [SIDE_W-1:0] side [QW+1];

    assign vld[0]  = in_vld;
    assign in_rdy  = rdy[0];
    assign rem[0]  = in_num;
    assign den[0]  = in_den;
    assign quo[0]  = '0;
    assign side[0] = in_side;

    for (genvar i = 0; i < QW; i++) begin : g_cell
        dpth_div_cell #(
            .NW(NW), .QW(QW), .SIDE_W(SIDE_W), .SHIFT(QW - 1 - i)
        ) u_cell (
            .aclk(aclk), .aresetn(aresetn),
            .in_vld(vld[i]), .in_rdy(rdy[i]),
            .in_rem(rem[i]), .in_den(den[i]), .in_quo(quo[i]), .in_side(side[i]),
            .out_vld(vld[i+1]), .out_rdy(rdy[i+1]),
            .out_rem(rem[i+1]), .out_den(den[i+1]), .out_quo(quo[i+1]),
            .out_side(side[i+1])
        );
    end

    assign rdy[QW]  = out_rdy;
    assign out_vld  = vld[QW];
    assign out_rem  = rem[QW];
    assign out_den  = den[QW];
    assign out_quo  = quo[QW];
    assign out_side = side[QW];
endmodule
`default_nettype wire

// ===== src/dew_point_from_temp_humidity.sv =====
// Top level: pipelined Magnus dew point with two chains of division cells.
// An item passes stage 0, the first chain, stage g, stage m, the second chain and the output register.
// Throughput: one item per cycle while the output is not stalled; each division cell settles one quotient bit.
// The first chain has FRAC_BITS + 5 cells, the second has ten.
// A stalled output holds back each stage only once the stages ahead of it are full.
// Reset clears all stage valid flags; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
`include "dew_point_from_temp_humidity_macros.svh"
module dew_point_from_temp_humidity import dpth_pkg::*; #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic signed [7:0] s_temp_c,
    input  wire logic [6:0]       s_rel_humidity,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic signed [7:0]     m_dew_point_c,
    output logic                  m_bad_humidity
);
    localparam int unsigned F    = FRAC_BITS;
    localparam int unsigned A_W  = F + 5;
    localparam int unsigned B_W  = F + 8;
    localparam int unsigned NW   = 2 * F + 13;
    localparam int unsigned QW1  = F + 5;
    localparam int unsigned LN_W = F + 4;
    localparam int unsigned G_W  = F + 6;
    localparam int unsigned S1_W = LN_W + 2;
    localparam logic [63:0] A_Q64 = ((64'(A_NUM) << F) + 64'(A_DEN / 2)) / A_DEN;
    localparam logic [63:0] B_Q64 = ((64'(B_NUM) << F) + 64'(B_DEN / 2)) / B_DEN;
    localparam logic [A_W-1:0] A_Q = A_Q64[A_W-1:0];
    localparam logic [B_W-1:0] B_Q = B_Q64[B_W-1:0];

    // ln(rh/100) in signed Q(FRAC_BITS); entry zero is read only for zero humidity, whose result is forced to zero.
    logic signed [LN_W-1:0] ln_tab [128];
    for (genvar n = 0; n < 128; n++) begin : g_ln
        localparam logic signed [63:0] LV = ln_ratio_qf((n == 0) ? 1 : n, F);
        assign ln_tab[n] = LV[LN_W-1:0];
    end

    // Stage 0: numerator and divisor of a*T/(b+T).
    logic              p0_vld_reg;
    logic              p0_rdy;
    logic [NW-1:0]     p0_num_reg, p0_num_next;
    logic [NW-1:0]     p0_den_reg, p0_den_next;
    logic [S1_W-1:0]   p0_side_reg, p0_side_next;
    logic [7:0]        t_mag;
    logic [A_W+7:0]    p0_prod;
    logic signed [F+9:0] den1_s;

    always_comb begin
        t_mag        = s_temp_c[7] ? 8'(-s_temp_c) : 8'(s_temp_c);
        p0_prod      = (A_W+8)'(A_Q) * (A_W+8)'(t_mag);
        p0_num_next  = {p0_prod, {F{1'b0}}};
        den1_s       = signed'({2'b00, B_Q}) + signed'({{2{s_temp_c[7]}}, s_temp_c, {F{1'b0}}});
        p0_den_next  = NW'(den1_s[F+8:0]);
        p0_side_next = {(s_rel_humidity == 7'd0), s_temp_c[7], ln_tab[s_rel_humidity]};
    end

    assign s_ready = !p0_vld_reg || p0_rdy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_vld_reg <= 1'b0;
        end else if (s_ready) begin
            p0_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            p0_num_reg  <= p0_num_next;
            p0_den_reg  <= p0_den_next;
            p0_side_reg <= p0_side_next;
        end
    end

    // First divider: magnitude of the temperature term.
    logic            c1_vld, c1_rdy;
    logic [NW-1:0]   c1_rem, c1_den;
    logic [QW1-1:0]  c1_quo;
    logic [S1_W-1:0] c1_side;

    dpth_div_chain #(.NW(NW), .QW(QW1), .SIDE_W(S1_W)) u_div1 (
        .aclk(aclk), .aresetn(aresetn),
        .in_vld(p0_vld_reg), .in_rdy(p0_rdy),
        .in_num(p0_num_reg), .in_den(p0_den_reg), .in_side(p0_side_reg),
        .out_vld(c1_vld), .out_rdy(c1_rdy),
        .out_rem(c1_rem), .out_den(c1_den), .out_quo(c1_quo), .out_side(c1_side)
    );

    // Stage g: gamma and a - gamma.
    logic                  g_vld_reg, g_rdy;
    logic signed [G_W-1:0] g_gamma_reg, g_gamma_next;
    logic [G_W-1:0]        g_den_reg, g_den_next;
    logic                  g_bad_reg;
    logic signed [G_W-1:0] term, gden_s;

    always_comb begin
        term         = c1_side[LN_W] ? -signed'({1'b0, c1_quo}) : signed'({1'b0, c1_quo});
        g_gamma_next = term + G_W'(signed'(c1_side[LN_W-1:0]));
        gden_s       = signed'(G_W'(A_Q)) - g_gamma_next;
        g_den_next   = unsigned'(gden_s);
    end

    assign c1_rdy = !g_vld_reg || g_rdy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_vld_reg <= 1'b0;
        end else if (c1_rdy) begin
            g_vld_reg <= c1_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (c1_rdy && c1_vld) begin
            g_gamma_reg <= g_gamma_next;
            g_den_reg   <= g_den_next;
            g_bad_reg   <= c1_side[S1_W-1];
        end
    end

    // Stage m: b * |gamma| over (a - gamma) scaled to whole degrees.
    logic              m2_vld_reg, m2_rdy;
    logic [NW-1:0]     m2_num_reg, m2_num_next;
    logic [NW-1:0]     m2_den_reg, m2_den_next;
    logic [1:0]        m2_side_reg;
    logic [G_W-1:0]    g_mag;
    logic [B_W+G_W-1:0] m2_prod;

    always_comb begin
        g_mag       = g_gamma_reg[G_W-1] ? unsigned'(-g_gamma_reg) : unsigned'(g_gamma_reg);
        m2_prod     = (B_W+G_W)'(B_Q) * (B_W+G_W)'(g_mag);
        m2_num_next = m2_prod[NW-1:0];
        m2_den_next = NW'({g_den_reg, {F{1'b0}}});
    end

    assign g_rdy = !m2_vld_reg || m2_rdy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m2_vld_reg <= 1'b0;
        end else if (g_rdy) begin
            m2_vld_reg <= g_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (g_rdy && g_vld_reg) begin
            m2_num_reg  <= m2_num_next;
            m2_den_reg  <= m2_den_next;
            m2_side_reg <= {g_bad_reg, g_gamma_reg[G_W-1]};
        end
    end

    // Second divider yields whole degrees directly.
    logic              c2_vld, c2_rdy;
    logic [NW-1:0]     c2_rem, c2_den;
    logic [DEG_QW-1:0] c2_quo;
    logic [1:0]        c2_side;

    dpth_div_chain #(.NW(NW), .QW(DEG_QW), .SIDE_W(2)) u_div2 (
        .aclk(aclk), .aresetn(aresetn),
        .in_vld(m2_vld_reg), .in_rdy(m2_rdy),
        .in_num(m2_num_reg), .in_den(m2_den_reg), .in_side(m2_side_reg),
        .out_vld(c2_vld), .out_rdy(c2_rdy),
        .out_rem(c2_rem), .out_den(c2_den), .out_quo(c2_quo), .out_side(c2_side)
    );

    // Output register: sign, saturation and the zero humidity case.
    logic              out_vld_reg;
    logic signed [7:0] dew_reg, dew_next;
    logic              bad_reg;

    always_comb begin
        if (c2_side[1]) begin
            dew_next = 8'sd0;
        end else if (c2_side[0]) begin
            dew_next = (c2_quo >= DEG_QW'(-DEW_MIN)) ? 8'(DEW_MIN) : -signed'(c2_quo[7:0]);
        end else begin
            dew_next = (c2_quo > DEG_QW'(DEW_MAX)) ? 8'(DEW_MAX) : signed'(c2_quo[7:0]);
        end
    end

    assign c2_rdy = !out_vld_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (c2_rdy) begin
            out_vld_reg <= c2_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (c2_rdy && c2_vld) begin
            dew_reg <= dew_next;
            bad_reg <= c2_side[1];
        end
    end

    assign m_valid        = out_vld_reg;
    assign m_dew_point_c  = dew_reg;
    assign m_bad_humidity = bad_reg;

    `DPTH_ASSERT(a_bad_gives_zero, aclk, aresetn, (m_valid && m_bad_humidity) |-> (m_dew_point_c == 8'sd0))
    `DPTH_ASSERT(a_dew_in_range, aclk, aresetn, m_valid |-> (m_dew_point_c >= -8'sd80 && m_dew_point_c <= 8'sd85))
    `DPTH_ASSERT(a_stall_only_from_output, aclk, aresetn, !s_ready |-> (m_valid && !m_ready))
    `DPTH_NEVER(a_div1_rem_small, aclk, aresetn, c1_vld && (c1_rem >= c1_den))
    `DPTH_NEVER(a_div2_rem_small, aclk, aresetn, c2_vld && (c2_rem >= c2_den))
endmodule
`default_nettype wire
